FILE: hdl/nlt_pkg.sv
package nlt_pkg;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_NORM,
    ST_SQR,
    ST_LNM,
    ST_RND
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [15:0] SCALE_RESET   = 16'd256;  // 1.0 in Q8.8
  localparam int          ONE_Q8        = 256;      // zero peak reads as 1.0
  localparam int          RATIO_FRAC    = 16;
  localparam int          SCALE_BITS    = 16;
  localparam int          LOG_FRAC_BITS = 28;
  localparam int          MANT_BITS     = 31;       // Q1.30 mantissa
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam int          OUT_BITS      = 16;

endpackage

FILE: hdl/nlt_div.sv
// Restoring divider, one quotient bit per cycle.
// Quotient = floor(mag * 2^16 / divisor).
module nlt_div #(
  parameter int P = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [P-1:0]                   mag,
  input  logic [P-1:0]                   divisor,
  output logic [P+nlt_pkg::RATIO_FRAC-1:0] quot,
  output nlt_pkg::div_stat_t             stat
);

  localparam int QW = P + nlt_pkg::RATIO_FRAC;
  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] dq_r, dq_nxt;
  logic [P-1:0]  rem_r, rem_nxt;
  logic [P-1:0]  dvs_r, dvs_nxt;
  logic [P:0]    rem_sh;
  logic          ge;

  // One restoring step
  always_comb begin
    rem_sh   = {rem_r, dq_r[QW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = {mag, {nlt_pkg::RATIO_FRAC{1'b0}}};
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? P'(rem_sh - {1'b0, dvs_r}) : P'(rem_sh);
      dq_nxt  = {dq_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quot      = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // Remainder stays below the divisor between steps
  a_rem_lt_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dvs_r || dvs_r == '0)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

FILE: hdl/normalized_log_transform.sv
// Measure item: accepted without leaving idle, updates the peak, no result.
// Transform item: divide (one quotient bit per cycle), scale multiply
// (one scale bit per cycle), normalize (one bit shift per cycle), log2 by
// squaring (one fraction bit per squaring), ln2 multiply, then round.
// One item in flight; the next transfer can be taken in the cycle after the result
// register loads. Reset (sync, low): peak 0, scale 1.0.
module normalized_log_transform #(
  parameter int PIXEL_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic                  in_first,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_log_value,
  output logic                  out_last_out
);

  localparam int P   = PIXEL_BITS;
  localparam int QW  = P + nlt_pkg::RATIO_FRAC;
  localparam int YW  = P + 32;
  localparam int IW  = $clog2(P + 8);
  localparam int LGW = IW + nlt_pkg::LOG_FRAC_BITS;
  localparam int PW  = LGW + 30;
  localparam int RW  = PW + 1 - 46;
  localparam int CW  = $clog2(YW + 1);
  localparam int MW  = nlt_pkg::MANT_BITS;

  nlt_pkg::state_t state_r, state_nxt;

  logic [15:0]     scale_r;
  logic [P-1:0]    peak_r, peak_nxt;
  logic            last_r, last_nxt;
  logic [15:0]     sc_r, sc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [YW-1:0]   acc_r, acc_nxt;
  logic [IW-1:0]   ip_r, ip_nxt;
  logic [MW-1:0]   m_r, m_nxt;
  logic [LGW-1:0]  lg_r, lg_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     log_value_r, log_value_nxt;
  logic            last_out_r, last_out_nxt;

  logic            in_xfer;
  logic [P-1:0]    mag;
  logic [P-1:0]    divisor;
  logic            div_start;
  logic [QW-1:0]   ratio;
  nlt_pkg::div_stat_t dstat;
  logic [2*MW-1:0] sq_full;
  logic [31:0]     sq;
  logic [PW:0]     rnd_sum;
  logic [RW-1:0]   rnd_q;
  logic            out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = state_r != nlt_pkg::ST_IDLE;
  assign mag      = in_pixel[P-1] ? P'(-in_pixel) : in_pixel;
  assign divisor  = (peak_r == '0) ? P'(nlt_pkg::ONE_Q8) : peak_r;
  assign div_start = in_xfer && in_operation;
  assign out_free  = !out_valid_r || !out_stall;

  nlt_div #(.P(P)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (mag),
    .divisor (divisor),
    .quot    (ratio),
    .stat    (dstat)
  );

  // Squaring and rounding datapath
  always_comb begin
    sq_full = m_r * m_r;
    sq      = sq_full[61:30];
    rnd_sum = {1'b0, prod_r} + (PW+1)'(64'd1 << 45);
    rnd_q   = rnd_sum[PW:46];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    peak_nxt      = peak_r;
    last_nxt      = last_r;
    sc_nxt        = sc_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    ip_nxt        = ip_r;
    m_nxt         = m_r;
    lg_nxt        = lg_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    log_value_nxt = log_value_r;
    last_out_nxt  = last_out_r;
    case (state_r)
      nlt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!in_operation) begin
            if (in_first || mag > peak_r) peak_nxt = mag;
          end else begin
            last_nxt  = in_last;
            sc_nxt    = scale_r;
            state_nxt = nlt_pkg::ST_DIV;
          end
        end
      end
      nlt_pkg::ST_DIV: begin
        if (dstat.done) begin
          cnt_nxt   = '0;
          acc_nxt   = YW'(nlt_pkg::ONE_Q8);  // becomes 2^24 after 16 shifts
          state_nxt = nlt_pkg::ST_MUL;
        end
      end
      nlt_pkg::ST_MUL: begin
        // y = 1 + scale*ratio, one scale bit per cycle, MSB first
        acc_nxt = (acc_r << 1) + (sc_r[15] ? YW'(ratio) : '0);
        sc_nxt  = sc_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(nlt_pkg::SCALE_BITS - 1)) begin
          ip_nxt    = IW'(P + 7);
          state_nxt = nlt_pkg::ST_NORM;
        end
      end
      nlt_pkg::ST_NORM: begin
        if (!acc_r[YW-1]) begin
          acc_nxt = acc_r << 1;
          ip_nxt  = ip_r - 1'b1;
        end else begin
          m_nxt     = acc_r[YW-1 -: MW];
          lg_nxt    = LGW'(ip_r);
          cnt_nxt   = '0;
          state_nxt = nlt_pkg::ST_SQR;
        end
      end
      nlt_pkg::ST_SQR: begin
        // one log2 fraction bit per squaring
        m_nxt   = sq[31] ? sq[31:1] : sq[30:0];
        lg_nxt  = {lg_r[LGW-2:0], sq[31]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(nlt_pkg::LOG_FRAC_BITS - 1)) begin
          cnt_nxt   = '0;
          prod_nxt  = '0;
          state_nxt = nlt_pkg::ST_LNM;
        end
      end
      nlt_pkg::ST_LNM: begin
        // times ln2, one bit of log2 per cycle
        prod_nxt = (prod_r << 1) + (lg_r[LGW-1] ? PW'(nlt_pkg::LN2_Q30) : '0);
        lg_nxt   = lg_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(LGW - 1)) state_nxt = nlt_pkg::ST_RND;
      end
      nlt_pkg::ST_RND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          log_value_nxt = (rnd_q > RW'(16'hFFFF)) ? 16'hFFFF : rnd_q[15:0];
          last_out_nxt  = last_r;
          state_nxt     = nlt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nlt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlt_pkg::ST_IDLE;
      scale_r     <= nlt_pkg::SCALE_RESET;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= cfg_we ? cfg_data : scale_r;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r      <= last_nxt;
    sc_r        <= sc_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    ip_r        <= ip_nxt;
    m_r         <= m_nxt;
    lg_r        <= lg_nxt;
    prod_r      <= prod_nxt;
    log_value_r <= log_value_nxt;
    last_out_r  <= last_out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_log_value = log_value_r;
  assign out_last_out  = last_out_r;

  a_measure_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_operation |=> state_r == nlt_pkg::ST_IDLE)
    else $error("measure transfer left the idle state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> state_r == nlt_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.busy |-> state_r == nlt_pkg::ST_DIV)
    else $error("divider running outside the divide state");

  a_mant_normal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nlt_pkg::ST_SQR |-> m_r[MW-1])
    else $error("mantissa lost normalization");

endmodule
